[hdl/mpsw_pkg.sv]
`default_nettype none
package mpsw_pkg;

	localparam logic [1:0] ACT_SEND    = 2'd0;
	localparam logic [1:0] ACT_RECV    = 2'd1;
	localparam logic [1:0] ACT_TIMEOUT = 2'd2;

	localparam int unsigned PEER_W   = 8;
	localparam int unsigned PEER_IDS = 256;

	typedef struct packed {
		logic next_send;
		logic ack_exp;
		logic frame_exp;
		logic timer_run;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]        action;
		logic [PEER_W-1:0] peer;
		logic              frame_is_ack;
		logic              frame_seq;
		logic              checksum_ok;
	} item_t;

	typedef struct packed {
		logic              send_frame;
		logic              send_is_ack;
		logic              send_seq;
		logic [PEER_W-1:0] send_peer;
		logic              from_stored;
		logic              deliver;
		logic              timer_start;
		logic              timer_stop;
		logic              app_enabled;
		logic              dropped;
	} result_t;

endpackage
`default_nettype wire

[hdl/mpsw_ram.sv]
`default_nettype none
module mpsw_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[hdl/mpsw_step.sv]
`default_nettype none
module mpsw_step
	import mpsw_pkg::*;
(
	input  wire item_t   item,
	input  wire entry_t  entry_in,
	input  wire logic    app_en_in,
	output entry_t       entry_out,
	output logic         app_en_out,
	output result_t      res
);

	always_comb begin
		entry_out  = entry_in;
		app_en_out = app_en_in;
		res        = '0;
		unique case (item.action)
			ACT_SEND: begin
				if (app_en_in) begin
					res.send_frame      = 1'b1;
					res.send_seq        = entry_in.next_send;
					res.send_peer       = item.peer;
					res.timer_start     = 1'b1;
					entry_out.timer_run = 1'b1;
					entry_out.next_send = ~entry_in.next_send;
					app_en_out          = 1'b0;
				end
			end
			ACT_RECV: begin
				if (!item.checksum_ok) begin
					res.dropped = 1'b1;
				end else if (item.frame_is_ack) begin
					if (item.frame_seq == entry_in.ack_exp) begin
						res.timer_stop      = 1'b1;
						entry_out.timer_run = 1'b0;
						entry_out.ack_exp   = ~entry_in.ack_exp;
						app_en_out          = 1'b1;
					end else begin
						res.dropped = 1'b1;
					end
				end else begin
					if (item.frame_seq == entry_in.frame_exp) begin
						res.deliver         = 1'b1;
						entry_out.frame_exp = ~entry_in.frame_exp;
					end else begin
						res.dropped = 1'b1;
					end
					res.send_frame  = 1'b1;
					res.send_is_ack = 1'b1;
					res.send_seq    = item.frame_seq;
					res.send_peer   = item.peer;
				end
			end
			ACT_TIMEOUT: begin
				if (entry_in.timer_run) begin
					res.send_frame  = 1'b1;
					res.send_seq    = entry_in.ack_exp;
					res.send_peer   = item.peer;
					res.from_stored = 1'b1;
					res.timer_start = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.app_enabled = app_en_out;
	end

endmodule
`default_nettype wire

[hdl/multi_peer_stop_and_wait_control.sv]
// pipeline: an accepted word is looked up in stage s1, then its result word is registered at the output
// throughput: one word per cycle while the output is not stalled; per-peer bits sit in a ram with a one-entry bypass
// reset: arst_n asynchronous active low, clears valid bits, timer marks read as zero
// reset: application enable comes up set, no ram clearing pass needed
`default_nettype none
module multi_peer_stop_and_wait_control
	import mpsw_pkg::*;
#(
	parameter int unsigned PEERS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// peer[7:0], frame_seq[8], checksum_ok[9], zero fill
	input  wire logic [15:0] s_axis_tdata,
	// action[1:0], frame_is_ack[2]
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// send_frame[0], send_seq[1], send_peer[9:2], from_stored[10], deliver[11],
	// timer_start[12], timer_stop[13], app_enabled[14], dropped[15]
	output logic      [15:0] m_axis_tdata,
	// send_is_ack[0]
	output logic      [0:0]  m_axis_tuser
);

	localparam int unsigned USED  = (PEERS < PEER_IDS) ? PEERS : PEER_IDS;
	localparam int unsigned IDX_W = $clog2(USED);

	// peer id to table entry
	logic [IDX_W-1:0] peer_map [PEER_IDS];

	for (genvar i = 0; i < PEER_IDS; i++) begin : g_map
		localparam int unsigned M = i % PEERS;
		assign peer_map[i] = IDX_W'(M);
	end

	item_t            item_in;
	logic [IDX_W-1:0] idx_in;
	logic             accept;
	logic             advance;

	item_t            item_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             valid_s1;
	logic             byp_s1;
	entry_t           byp_data_s1;

	logic [USED-1:0]  entry_valid_q;
	logic             app_en_q;

	logic [ENTRY_W-1:0] rdata;
	entry_t             entry_cur;
	entry_t             entry_nxt;
	logic               app_en_nxt;
	result_t            res;
	result_t            res_q;
	logic               out_valid_q;

	assign item_in.action       = s_axis_tuser[1:0];
	assign item_in.frame_is_ack = s_axis_tuser[2];
	assign item_in.peer         = s_axis_tdata[PEER_W-1:0];
	assign item_in.frame_seq    = s_axis_tdata[8];
	assign item_in.checksum_ok  = s_axis_tdata[9];
	assign idx_in               = peer_map[item_in.peer];

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	mpsw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(USED)
	) u_ram (
		.clk  (clk),
		.we   (advance),
		.waddr(idx_s1),
		.wdata(entry_nxt),
		.re   (accept),
		.raddr(idx_in),
		.rdata(rdata)
	);

	always_comb begin
		priority if (byp_s1) begin
			entry_cur = byp_data_s1;
		end else if (entry_valid_q[idx_s1]) begin
			entry_cur = entry_t'(rdata);
		end else begin
			entry_cur = '0;
		end
	end

	mpsw_step u_step (
		.item      (item_s1),
		.entry_in  (entry_cur),
		.app_en_in (app_en_q),
		.entry_out (entry_nxt),
		.app_en_out(app_en_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			byp_s1        <= 1'b0;
			entry_valid_q <= '0;
			app_en_q      <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				byp_s1   <= advance && (idx_in == idx_s1);
			end else if (advance) begin
				valid_s1 <= 1'b0;
				byp_s1   <= 1'b0;
			end
			if (advance) begin
				entry_valid_q[idx_s1] <= 1'b1;
				app_en_q              <= app_en_nxt;
				out_valid_q           <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item_in;
			idx_s1      <= idx_in;
			byp_data_s1 <= entry_nxt;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid     = out_valid_q;
	assign m_axis_tuser[0]   = res_q.send_is_ack;
	assign m_axis_tdata[0]   = res_q.send_frame;
	assign m_axis_tdata[1]   = res_q.send_seq;
	assign m_axis_tdata[9:2] = res_q.send_peer;
	assign m_axis_tdata[10]  = res_q.from_stored;
	assign m_axis_tdata[11]  = res_q.deliver;
	assign m_axis_tdata[12]  = res_q.timer_start;
	assign m_axis_tdata[13]  = res_q.timer_stop;
	assign m_axis_tdata[14]  = res_q.app_enabled;
	assign m_axis_tdata[15]  = res_q.dropped;

endmodule
`default_nettype wire
